// File: design/ycc420_pkg.sv
// Shared types and constants for the YCoCg to 4:2:0 converter.
package ycc420_pkg;

	localparam int PIX_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int CFG_W   = 12;
	localparam int CIDX_W  = 2;
	localparam int PSUM_W  = 17;
	localparam int BSUM_W  = 18;
	localparam int ACC_W   = 28;
	localparam int ENTRY_W = 2 * PSUM_W;

	typedef enum logic [CIDX_W-1:0] {
		CFG_ROW_WIDTH    = 2'd0,
		CFG_LEVEL_OFFSET = 2'd1,
		CFG_CHROMA_ORDER = 2'd2
	} cfg_index_t;

	localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 12'd2048;

	localparam logic signed [ACC_W-1:0] K_Y      = 28'sd440;
	localparam logic signed [ACC_W-1:0] K_Y_CO   = 28'sd82;
	localparam logic signed [ACC_W-1:0] K_Y_CG   = 28'sd76;
	localparam logic signed [ACC_W-1:0] K_U_CO   = 28'sd150;
	localparam logic signed [ACC_W-1:0] K_U_CG   = 28'sd148;
	localparam logic signed [ACC_W-1:0] K_V_CO   = 28'sd130;
	localparam logic signed [ACC_W-1:0] K_V_CG   = 28'sd188;
	localparam logic signed [ACC_W-1:0] Y_ROUND  = 28'sd4096;
	localparam logic signed [ACC_W-1:0] C_ROUND  = 28'sd8192;
	localparam logic signed [ACC_W-1:0] Y_BIAS   = 28'sd16;
	localparam logic signed [ACC_W-1:0] C_BIAS   = 28'sd128;
	localparam int Y_SHIFT = 13;
	localparam int C_SHIFT = 14;

	typedef struct packed {
		logic [CFG_W-1:0]        row_width;
		logic signed [CFG_W-1:0] level_offset;
		logic                    chroma_order_i420;
	} cfg_t;

	// one classified pixel travelling from front to back
	typedef struct packed {
		logic signed [PIX_W-1:0]  luma;
		logic signed [PIX_W-1:0]  orange;
		logic signed [PIX_W-1:0]  green;
		logic                     chroma;
		logic signed [BSUM_W-1:0] sum_orange;
		logic signed [BSUM_W-1:0] sum_green;
	} work_t;

endpackage

// File: design/ycc420_pixel_if.sv
// Pixel input channel.
interface ycc420_pixel_if;
	import ycc420_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    frame_begin;
	logic signed [PIX_W-1:0] luma_in;
	logic signed [PIX_W-1:0] orange_in;
	logic signed [PIX_W-1:0] green_in;

	modport source (output valid, frame_begin, luma_in, orange_in, green_in, input ready);
	modport sink   (input valid, frame_begin, luma_in, orange_in, green_in, output ready);
endinterface

// File: design/ycc420_result_if.sv
// Result output channel.
interface ycc420_result_if;
	import ycc420_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] luma_out;
	logic              chroma_valid;
	logic [BYTE_W-1:0] chroma_first;
	logic [BYTE_W-1:0] chroma_second;
	logic              range_overflow;

	modport source (output valid, luma_out, chroma_valid, chroma_first, chroma_second,
		range_overflow, input ready);
	modport sink   (input valid, luma_out, chroma_valid, chroma_first, chroma_second,
		range_overflow, output ready);
endinterface

// File: design/ycc420_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ycc420_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: design/ycc420_front.sv
// Front end: raster tracking, 2x2 sum gathering through the line buffer, classification.
module ycc420_front #(
	parameter int MAX_ROW_WIDTH = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ycc420_pkg::cfg_t    cfg,
	ycc420_pixel_if.sink        pixel,
	output logic                push,
	output ycc420_pkg::work_t   push_data,
	input  logic                q_full
);
	import ycc420_pkg::*;

	localparam int COL_W      = $clog2(MAX_ROW_WIDTH);
	localparam int LINE_DEPTH = MAX_ROW_WIDTH / 2;
	localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int EW_W       = ($clog2(MAX_ROW_WIDTH + 1) > CFG_W) ?
		$clog2(MAX_ROW_WIDTH + 1) : CFG_W;

	logic [COL_W-1:0]         col_q;
	logic                     odd_q;
	logic signed [PIX_W-1:0]  held_co_q, held_cg_q;

	logic                     valid_s1, chroma_s1;
	logic signed [PIX_W-1:0]  luma_s1, co_s1, cg_s1;
	logic signed [PSUM_W-1:0] pco_s1, pcg_s1;

	logic                     accept;
	logic [COL_W-1:0]         col_cur;
	logic                     odd_cur;
	logic [EW_W-1:0]          w_raw, w_clamp, w_eff;
	logic [EW_W:0]            col_p1;
	logic                     row_end;
	logic [LINE_AW-1:0]       pos;
	logic signed [PSUM_W-1:0] pco, pcg;
	logic                     line_we, line_re;
	logic [ENTRY_W-1:0]       line_rdata;
	logic signed [PSUM_W-1:0] line_co, line_cg;

	assign pixel.ready = !valid_s1 || !q_full;
	assign accept      = pixel.valid && pixel.ready;

	assign col_cur = pixel.frame_begin ? '0 : col_q;
	assign odd_cur = pixel.frame_begin ? 1'b0 : odd_q;

	// effective width: clamp to the maximum, force even, at least two
	always_comb begin
		w_raw   = EW_W'(cfg.row_width);
		w_clamp = (w_raw > EW_W'(MAX_ROW_WIDTH)) ? EW_W'(MAX_ROW_WIDTH) : w_raw;
		w_eff   = {w_clamp[EW_W-1:1], 1'b0};
		if (w_eff < EW_W'(2)) begin
			w_eff = EW_W'(2);
		end
	end

	assign col_p1  = (EW_W+1)'(col_cur) + (EW_W+1)'(1);
	assign row_end = col_p1 >= (EW_W+1)'(w_eff);
	assign pos     = LINE_AW'(col_cur >> 1);

	assign pco = PSUM_W'(held_co_q) + PSUM_W'(pixel.orange_in);
	assign pcg = PSUM_W'(held_cg_q) + PSUM_W'(pixel.green_in);

	assign line_we = accept && col_cur[0] && !odd_cur;
	assign line_re = accept && col_cur[0] && odd_cur;

	ycc420_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk  (clk),
		.we   (line_we),
		.waddr(pos),
		.wdata({pco, pcg}),
		.re   (line_re),
		.raddr(pos),
		.rdata(line_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			odd_q     <= 1'b0;
			held_co_q <= '0;
			held_cg_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				odd_q <= !odd_cur;
			end else begin
				col_q <= col_cur + COL_W'(1);
				odd_q <= odd_cur;
			end
			if (!col_cur[0]) begin
				held_co_q <= pixel.orange_in;
				held_cg_q <= pixel.green_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1   <= pixel.luma_in;
			co_s1     <= pixel.orange_in;
			cg_s1     <= pixel.green_in;
			chroma_s1 <= col_cur[0] && odd_cur;
			pco_s1    <= pco;
			pcg_s1    <= pcg;
		end
	end

	// line data is held in the RAM output register until the next odd-row read
	assign line_co = $signed(line_rdata[ENTRY_W-1:PSUM_W]);
	assign line_cg = $signed(line_rdata[PSUM_W-1:0]);

	assign push = valid_s1 && !q_full;

	always_comb begin
		push_data.luma       = luma_s1;
		push_data.orange     = co_s1;
		push_data.green      = cg_s1;
		push_data.chroma     = chroma_s1;
		push_data.sum_orange = BSUM_W'(line_co) + BSUM_W'(pco_s1);
		push_data.sum_green  = BSUM_W'(line_cg) + BSUM_W'(pcg_s1);
	end
endmodule

// File: design/ycc420_queue.sv
// Short request queue between front and back.
module ycc420_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ycc420_pkg::work_t push_data,
	output logic              full,
	input  logic              pop,
	output ycc420_pkg::work_t head,
	output logic              empty
);
	import ycc420_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	work_t           slot_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     count_q;

	assign full  = count_q == (AW+1)'(DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (AW+1)'(1);
				2'b01:   count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// File: design/ycc420_back.sv
// Back end: luma and chroma arithmetic, wrap to bytes, output register.
module ycc420_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ycc420_pkg::cfg_t  cfg,
	input  ycc420_pkg::work_t head,
	input  logic              q_empty,
	output logic              pop,
	ycc420_result_if.source   result
);
	import ycc420_pkg::*;

	logic                    adv;
	logic signed [15:0]      off16;
	logic signed [PIX_W:0]   ydiff;

	logic                    valid_s1, chroma_s1;
	logic signed [ACC_W-1:0] py_s1, pyco_s1, pycg_s1;
	logic signed [ACC_W-1:0] uco_s1, ucg_s1, vco_s1, vcg_s1;

	logic signed [ACC_W-1:0] lval, uval, vval;
	logic                    l_ovf, u_ovf, v_ovf;

	logic                    out_valid_q;
	logic [BYTE_W-1:0]       luma_q, first_q, second_q;
	logic                    cvalid_q, ovf_q;

	assign adv = !out_valid_q || result.ready;
	assign pop = adv && !q_empty;

	assign off16 = $signed({cfg.level_offset, 4'b0000});
	assign ydiff = (PIX_W+1)'(head.luma) - (PIX_W+1)'(off16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			chroma_s1 <= head.chroma;
			py_s1     <= ACC_W'(ydiff) * K_Y;
			pyco_s1   <= ACC_W'(head.orange) * K_Y_CO;
			pycg_s1   <= ACC_W'(head.green) * K_Y_CG;
			uco_s1    <= ACC_W'(head.sum_orange) * K_U_CO;
			ucg_s1    <= ACC_W'(head.sum_green) * K_U_CG;
			vco_s1    <= ACC_W'(head.sum_orange) * K_V_CO;
			vcg_s1    <= ACC_W'(head.sum_green) * K_V_CG;
		end
	end

	// floor shifts, then bias; anything with bits above 7 set lay outside 0..255
	always_comb begin
		lval  = ((py_s1 + pyco_s1 + pycg_s1 + Y_ROUND) >>> Y_SHIFT) + Y_BIAS;
		uval  = ((C_ROUND - uco_s1 - ucg_s1) >>> C_SHIFT) + C_BIAS;
		vval  = ((vco_s1 - vcg_s1 + C_ROUND) >>> C_SHIFT) + C_BIAS;
		l_ovf = lval[ACC_W-1:BYTE_W] != '0;
		u_ovf = uval[ACC_W-1:BYTE_W] != '0;
		v_ovf = vval[ACC_W-1:BYTE_W] != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			luma_q   <= lval[BYTE_W-1:0];
			cvalid_q <= chroma_s1;
			if (!chroma_s1) begin
				first_q  <= '0;
				second_q <= '0;
				ovf_q    <= l_ovf;
			end else begin
				first_q  <= cfg.chroma_order_i420 ? uval[BYTE_W-1:0] : vval[BYTE_W-1:0];
				second_q <= cfg.chroma_order_i420 ? vval[BYTE_W-1:0] : uval[BYTE_W-1:0];
				ovf_q    <= l_ovf || u_ovf || v_ovf;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.luma_out       = luma_q;
	assign result.chroma_valid   = cvalid_q;
	assign result.chroma_first   = first_q;
	assign result.chroma_second  = second_q;
	assign result.range_overflow = ovf_q;
endmodule

// File: design/ycocg_to_yuv420_converter.sv
// Scaled YCoCg to 8-bit 4:2:0 luma/chroma converter, one result per pixel.
// A pixel passes the front stage, the queue, the multiply stage and the output register in turn.
// Throughput: one pixel per cycle unless the queue fills; line buffer: one write or read per pair.
// Front and back are parted by a 4-entry queue, so output stalls reach the input only when it fills.
// Reset clears raster position, held chroma and valids, presets config; line buffer needs no clear.
module ycocg_to_yuv420_converter #(
	parameter int MAX_ROW_WIDTH = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ycc420_pkg::CIDX_W-1:0]      cfg_index,
	input  logic [ycc420_pkg::CFG_W-1:0]       cfg_wdata,
	ycc420_pixel_if.sink                       pixel,
	ycc420_result_if.source                    result
);
	import ycc420_pkg::*;

	cfg_t  cfg_q;
	logic  push, q_full, pop, q_empty;
	work_t push_data, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_width         <= ROW_WIDTH_RST;
			cfg_q.level_offset      <= '0;
			cfg_q.chroma_order_i420 <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_ROW_WIDTH:    cfg_q.row_width         <= cfg_wdata;
				CFG_LEVEL_OFFSET: cfg_q.level_offset      <= $signed(cfg_wdata);
				CFG_CHROMA_ORDER: cfg_q.chroma_order_i420 <= cfg_wdata[0];
				default:          cfg_q                   <= cfg_q;
			endcase
		end
	end

	ycc420_front #(
		.MAX_ROW_WIDTH(MAX_ROW_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pixel    (pixel),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	ycc420_queue #(
		.DEPTH(4)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	ycc420_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.q_empty(q_empty),
		.pop    (pop),
		.result (result)
	);
endmodule

// File: tb/sv/ycocg_to_yuv420_converter_tb.sv
// Self-checking testbench for the YCoCg to 4:2:0 converter: directed table, then random phases.
`timescale 1ns / 100ps

module ycocg_to_yuv420_converter_tb;
	import ycc420_pkg::*;

	localparam int MAX_ROW       = 2048;
	localparam int LINE_PAIRS    = MAX_ROW / 2;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_ITEMS   = 143;

	typedef struct packed {
		logic                    frame_begin;
		logic signed [PIX_W-1:0] luma;
		logic signed [PIX_W-1:0] orange;
		logic signed [PIX_W-1:0] green;
	} pixel_t;

	typedef struct packed {
		logic [BYTE_W-1:0] luma;
		logic              chroma_valid;
		logic [BYTE_W-1:0] chroma_first;
		logic [BYTE_W-1:0] chroma_second;
		logic              overflow;
	} yuv_result_t;

	typedef struct packed {
		logic        is_cfg;
		cfg_index_t  idx;
		logic [CFG_W-1:0] data;
		pixel_t      px;
		logic        typed;
		yuv_result_t want;
	} step_t;

	localparam pixel_t      NO_PIX = '0;
	localparam yuv_result_t NO_RES = '0;

	// typed expectations only where the arithmetic is trivial
	localparam step_t DIRECTED_STEPS [33] = '{
		'{1'b1, CFG_ROW_WIDTH, 12'd2, NO_PIX, 1'b0, NO_RES},
		'{1'b1, CFG_LEVEL_OFFSET, 12'd0, NO_PIX, 1'b0, NO_RES},
		'{1'b1, CFG_CHROMA_ORDER, 12'd0, NO_PIX, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b1, 16'h0000, 16'h0000, 16'h0000},
			1'b1, '{8'd16, 1'b0, 8'd0, 8'd0, 1'b0}},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h8000, 16'h0000, 16'h0000},
			1'b1, '{8'd48, 1'b0, 8'd0, 8'd0, 1'b1}},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h0000, 16'h7FFF, 16'h7FFF}, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h0000, 16'h7FFF, 16'h7FFF}, 1'b0, NO_RES},
		// no frame_begin: rows just keep alternating
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h7FFF, 16'h8000, 16'h8000}, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h7FFF, 16'h8000, 16'h8000}, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h8000, 16'h8000, 16'h7FFF}, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h8000, 16'h7FFF, 16'h8000}, 1'b0, NO_RES},
		'{1'b1, CFG_CHROMA_ORDER, 12'd1, NO_PIX, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b1, 16'h0100, 16'h0123, 16'hFF00}, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h0200, 16'hFFFF, 16'h0040}, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h0300, 16'h7FFF, 16'h7FFF}, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h0400, 16'h7FFF, 16'h7FFF}, 1'b0, NO_RES},
		'{1'b1, CFG_LEVEL_OFFSET, 12'h800, NO_PIX, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b1, 16'h8000, 16'h0000, 16'h0000},
			1'b1, '{8'd16, 1'b0, 8'd0, 8'd0, 1'b0}},
		'{1'b1, CFG_LEVEL_OFFSET, 12'h7FF, NO_PIX, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h7FFF, 16'h0000, 16'h0000}, 1'b0, NO_RES},
		// odd width drops bit 0
		'{1'b1, CFG_ROW_WIDTH, 12'd5, NO_PIX, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b1, 16'h0010, 16'h0010, 16'h0010}, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h0020, 16'hFFF0, 16'h0010}, 1'b0, NO_RES},
		// width shrinks mid-row: the row closes on the next pixel
		'{1'b1, CFG_ROW_WIDTH, 12'd2, NO_PIX, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h0030, 16'h0000, 16'h0000}, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h0040, 16'h0100, 16'h0200}, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h0050, 16'h0100, 16'h0200}, 1'b0, NO_RES},
		'{1'b1, CFG_ROW_WIDTH, 12'd1, NO_PIX, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b1, 16'h0060, 16'h0000, 16'h0000}, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'h0070, 16'h0000, 16'h0000}, 1'b0, NO_RES},
		'{1'b1, CFG_ROW_WIDTH, 12'hFFF, NO_PIX, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b1, 16'h1234, 16'h8000, 16'h7FFF}, 1'b0, NO_RES},
		'{1'b0, CFG_ROW_WIDTH, 12'd0, '{1'b0, 16'hEDCB, 16'h7FFF, 16'h8000}, 1'b0, NO_RES}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	cfg_index_t       cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	ycc420_pixel_if  pixel_ch ();
	ycc420_result_if result_ch ();

	ycocg_to_yuv420_converter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pixel     (pixel_ch),
		.result    (result_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow registers and raster state of the predictor
	logic [CFG_W-1:0]        width_reg  = ROW_WIDTH_RST;
	logic signed [CFG_W-1:0] offset_reg = '0;
	logic                    i420_reg   = 1'b0;
	int                      raster_col = 0;
	bit                      raster_odd = 1'b0;
	int                      hold_co    = 0;
	int                      hold_cg    = 0;
	int                      pair_sum_co [LINE_PAIRS];
	int                      pair_sum_cg [LINE_PAIRS];
	bit                      line_filled [LINE_PAIRS];

	yuv_result_t expected_yuv [$];
	int          mismatches   = 0;
	int          result_count = 0;
	int          cycle_count  = 0;
	int          src_idle_pct = 10;
	int          snk_idle_pct = 73;

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t ns: %s", $time, msg);
	endtask

	function automatic yuv_result_t convert_pixel(input pixel_t px);
		yuv_result_t r;
		longint      acc, sum_co, sum_cg, u_val, v_val;
		int          eff_w, pair;
		r = '0;
		eff_w = int'(width_reg);
		if (eff_w > MAX_ROW)
			eff_w = MAX_ROW;
		eff_w = eff_w & ~1;
		if (eff_w < 2)
			eff_w = 2;
		if (px.frame_begin) begin
			raster_col = 0;
			raster_odd = 1'b0;
		end

		acc = 440 * (longint'(px.luma) - 16 * longint'(offset_reg))
			+ 82 * longint'(px.orange) + 76 * longint'(px.green) + 4096;
		acc = (acc >>> 13) + 16;
		r.luma = acc[7:0];
		if (acc < 0 || acc > 255)
			r.overflow = 1'b1;

		pair = raster_col >> 1;
		if (pair >= LINE_PAIRS)
			pair = LINE_PAIRS - 1;

		if (raster_col % 2 == 0) begin
			hold_co = int'(px.orange);
			hold_cg = int'(px.green);
		end else if (!raster_odd) begin
			pair_sum_co[pair] = hold_co + int'(px.orange);
			pair_sum_cg[pair] = hold_cg + int'(px.green);
			line_filled[pair] = 1'b1;
		end else begin
			sum_co = longint'(pair_sum_co[pair]) + hold_co + longint'(px.orange);
			sum_cg = longint'(pair_sum_cg[pair]) + hold_cg + longint'(px.green);
			u_val = ((-150 * sum_co - 148 * sum_cg + 8192) >>> 14) + 128;
			v_val = ((130 * sum_co - 188 * sum_cg + 8192) >>> 14) + 128;
			if (u_val < 0 || u_val > 255 || v_val < 0 || v_val > 255)
				r.overflow = 1'b1;
			r.chroma_valid = 1'b1;
			if (i420_reg) begin
				r.chroma_first  = u_val[7:0];
				r.chroma_second = v_val[7:0];
			end else begin
				r.chroma_first  = v_val[7:0];
				r.chroma_second = u_val[7:0];
			end
		end

		if (raster_col + 1 >= eff_w) begin
			raster_col = 0;
			raster_odd = !raster_odd;
		end else begin
			raster_col++;
		end
		return r;
	endfunction

	// every task below starts and ends just after a falling edge
	task automatic send_pixel(input pixel_t px, input bit typed, input yuv_result_t want);
		yuv_result_t predicted;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pixel_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pixel_ch.valid       <= 1'b1;
		pixel_ch.frame_begin <= px.frame_begin;
		pixel_ch.luma_in     <= px.luma;
		pixel_ch.orange_in   <= px.orange;
		pixel_ch.green_in    <= px.green;
		@(posedge clk);
		while (!pixel_ch.ready)
			@(posedge clk);
		predicted = convert_pixel(px);
		expected_yuv.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic drain_results();
		pixel_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_yuv.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_ROW_WIDTH:    width_reg  = data;
			CFG_LEVEL_OFFSET: offset_reg = data;
			CFG_CHROMA_ORDER: i420_reg   = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic signed [PIX_W-1:0] pick_sample(input int centre, input int spread);
		int sel;
		sel = $urandom_range(0, 19);
		case (sel)
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4, 5, 6, 7, 8, 9: return 16'($urandom);
			default: return 16'(centre + int'($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	task automatic run_segment(input int n_items);
		pixel_t           px;
		logic [CFG_W-1:0] width_val, offset_val;
		int               pick, pair;
		bit               lead_fb;
		drain_results();
		pick = $urandom_range(0, 99);
		if (pick < 70)
			width_val = 12'($urandom_range(0, 17));
		else if (pick < 85)
			width_val = 12'($urandom_range(18, 80));
		else if (pick < 93)
			width_val = 12'd2048;
		else
			width_val = 12'($urandom_range(2049, 4095));
		pick = $urandom_range(0, 99);
		if (pick < 20)
			offset_val = 12'h800;
		else if (pick < 40)
			offset_val = 12'h7FF;
		else if (pick < 55)
			offset_val = '0;
		else
			offset_val = 12'($urandom);
		write_reg(CFG_ROW_WIDTH, width_val);
		write_reg(CFG_LEVEL_OFFSET, offset_val);
		write_reg(CFG_CHROMA_ORDER, 12'($urandom_range(0, 1)));
		lead_fb = 1'($urandom_range(0, 1));
		for (int i = 0; i < n_items; i++) begin
			px.frame_begin = (i == 0 && lead_fb) || ($urandom_range(0, 99) < 2);
			px.luma   = pick_sample(16 * int'(offset_reg) + 2200, 2300);
			px.orange = pick_sample(0, 3000);
			px.green  = pick_sample(0, 3000);
			// never let an odd row read a line entry that no even row has filled
			pair = raster_col >> 1;
			if (pair >= LINE_PAIRS)
				pair = LINE_PAIRS - 1;
			if (raster_odd && raster_col % 2 == 1 && !line_filled[pair])
				px.frame_begin = 1'b1;
			send_pixel(px, 1'b0, NO_RES);
		end
	endtask

	always @(negedge clk)
		result_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

	always @(posedge clk) begin
		yuv_result_t got, want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.luma_out, result_ch.chroma_valid, result_ch.chroma_first,
				result_ch.chroma_second, result_ch.range_overflow};
			result_count++;
			if (expected_yuv.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no pixel pending",
					result_count));
			end else begin
				want = expected_yuv.pop_front();
				if (got.luma != want.luma)
					report_mismatch($sformatf("result %0d luma_out: got %0d, expected %0d",
						result_count, got.luma, want.luma));
				if (got.chroma_valid != want.chroma_valid)
					report_mismatch($sformatf("result %0d chroma_valid: got %0d, expected %0d",
						result_count, got.chroma_valid, want.chroma_valid));
				if (got.chroma_first != want.chroma_first)
					report_mismatch($sformatf("result %0d chroma_first: got %0d, expected %0d",
						result_count, got.chroma_first, want.chroma_first));
				if (got.chroma_second != want.chroma_second)
					report_mismatch($sformatf("result %0d chroma_second: got %0d, expected %0d",
						result_count, got.chroma_second, want.chroma_second));
				if (got.overflow != want.overflow)
					report_mismatch($sformatf("result %0d range_overflow: got %0d, expected %0d",
						result_count, got.overflow, want.overflow));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int remaining, n_items;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_ROW_WIDTH;
		cfg_wdata            = '0;
		pixel_ch.valid       = 1'b0;
		pixel_ch.frame_begin = 1'b0;
		pixel_ch.luma_in     = '0;
		pixel_ch.orange_in   = '0;
		pixel_ch.green_in    = '0;
		result_ch.ready      = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED_STEPS[i]) begin
			if (DIRECTED_STEPS[i].is_cfg) begin
				drain_results();
				write_reg(DIRECTED_STEPS[i].idx, DIRECTED_STEPS[i].data);
			end else begin
				send_pixel(DIRECTED_STEPS[i].px, DIRECTED_STEPS[i].typed,
					DIRECTED_STEPS[i].want);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 10;
					snk_idle_pct = 73;
				end
				1: begin
					src_idle_pct = 73;
					snk_idle_pct = 10;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			remaining = PHASE_ITEMS;
			while (remaining > 0) begin
				n_items = $urandom_range(15, 45);
				if (n_items > remaining)
					n_items = remaining;
				run_segment(n_items);
				remaining -= n_items;
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: ycocg_to_yuv420_converter.f
design/ycc420_pkg.sv
design/ycc420_pixel_if.sv
design/ycc420_result_if.sv
design/ycc420_ram.sv
design/ycc420_front.sv
design/ycc420_queue.sv
design/ycc420_back.sv
design/ycocg_to_yuv420_converter.sv
tb/sv/ycocg_to_yuv420_converter_tb.sv
